>>> hdl/tgs_pkg.sv
`default_nettype none
package tgs_pkg;

    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int SAMPLE_W = 16;
    localparam int POS_W = 16;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] VOL_ELEV = 2'd0;
    localparam logic [1:0] VOL_PWAVE = 2'd1;
    localparam logic [1:0] VOL_SWAVE = 2'd2;

    localparam logic [1:0] STATUS_SAMPLED = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_STORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWAVE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWAVE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAVE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAVE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 3'd6;

    localparam int VAL_MAX = 8388607;
    localparam int VAL_MIN = -8388608;

    typedef struct packed {
        logic store;
        logic outside;
    } tgs_meta_t;

    typedef struct packed {
        logic [1:0] sel_x;
        logic [1:0] sel_y;
        logic [1:0] sel_z;
    } tgs_corner_t;

endpackage
`default_nettype wire

>>> hdl/tgs_bank.sv
`default_nettype none
module tgs_bank #(
    parameter int AW = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic signed [tgs_pkg::SAMPLE_W-1:0]   wdata,
    input  logic                                  re,
    input  logic [AW-1:0]                         raddr,
    output logic signed [tgs_pkg::SAMPLE_W-1:0]   rdata
);
    import tgs_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [2**AW];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/tgs_coord.sv
`default_nettype none
module tgs_coord #(
    parameter int IW = 6,
    parameter int FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [tgs_pkg::POS_W-1:0]  pos,
    input  logic [IW:0]                       size,
    output logic [IW-1:0]                     idx0,
    output logic [IW-1:0]                     idx1,
    output logic signed [FRAC_BITS:0]         frac,
    output logic                              outside
);
    import tgs_pkg::*;

    localparam int MW = POS_W + 1;
    localparam int RW = POS_W + 2;
    localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

    logic signed [MW-1:0] pos_ext;
    logic [MW-1:0]        mag;
    logic [RW-1:0]        rnd;
    logic [FRAC_BITS-1:0] mag_frac;
    logic [IW:0]          idx_inc;

    logic [IW-1:0]          t_reg;
    logic [IW:0]            size_reg;
    logic signed [FRAC_BITS:0] frac_reg;
    logic                   outside_reg;

    always_comb begin
        pos_ext = MW'(pos);
        mag = pos[POS_W-1] ? $unsigned(-pos_ext) : $unsigned(pos_ext);
        rnd = (RW'(mag) + HALF) >> FRAC_BITS;
        mag_frac = mag[FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= IW'(mag >> FRAC_BITS);
            size_reg <= size;
            frac_reg <= pos[POS_W-1] ? -$signed({1'b0, mag_frac}) : $signed({1'b0, mag_frac});
            outside_reg <= (pos[POS_W-1] && (rnd != '0)) || (rnd >= RW'(size));
        end
    end

    // Upper corner is clamped to the last cell of the grid.
    always_comb begin
        idx_inc = (IW+1)'(t_reg) + (IW+1)'(1);
        idx0 = t_reg;
        idx1 = (idx_inc >= size_reg) ? t_reg : IW'(idx_inc);
    end

    assign frac = frac_reg;
    assign outside = outside_reg;

endmodule
`default_nettype wire

>>> hdl/tgs_interp.sv
`default_nettype none
module tgs_interp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tgs_pkg::tgs_meta_t                   in_meta,
    input  logic [1:0]                           in_vol,
    input  tgs_pkg::tgs_corner_t                 in_corner,
    input  logic signed [FRAC_BITS:0]            in_fx,
    input  logic signed [FRAC_BITS:0]            in_fy,
    input  logic signed [FRAC_BITS:0]            in_fz,
    input  logic signed [tgs_pkg::SAMPLE_W-1:0]  elev_q [4],
    input  logic signed [tgs_pkg::SAMPLE_W-1:0]  pw_q [8],
    input  logic signed [tgs_pkg::SAMPLE_W-1:0]  sw_q [8],
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tgs_pkg::M_DATA_W-1:0]         m_tdata,
    output logic [tgs_pkg::M_USER_W-1:0]         m_tuser
);
    import tgs_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int LW = SAMPLE_W + 2 + F;
    localparam int DW = LW + 1;
    localparam int PYW = DW + F + 1;
    localparam int VW = LW + 2;
    localparam int EW = VW + 1;
    localparam int PZW = EW + F + 1;
    localparam logic [PZW:0] HALF = (PZW+1)'(1) << (F - 1);
    localparam logic [M_DATA_W-1:0] OUTSIDE_VALUE = M_DATA_W'(-(1 << FRAC_BITS));

    function automatic logic signed [PZW-1:0] scale_down(input logic signed [PZW-1:0] p);
        logic signed [PZW:0] pe;
        logic [PZW:0]        m;
        logic [PZW:0]        r;
        pe = (PZW+1)'(p);
        m = pe[PZW] ? $unsigned(-pe) : $unsigned(pe);
        r = (m + HALF) >> F;
        return pe[PZW] ? PZW'(-$signed(r)) : PZW'($signed(r));
    endfunction

    logic en3, en4, en5, en6, en_out;

    logic v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    tgs_meta_t meta3_reg, meta4_reg, meta5_reg, meta6_reg;
    logic signed [F:0] fy3_reg, fz3_reg, fz4_reg, fz5_reg;

    logic signed [SAMPLE_W-1:0] q_sel [8];
    logic signed [SAMPLE_W:0]   dq [4];
    logic signed [LW-1:0]       xl_next [4];
    logic signed [LW-1:0]       xl_reg [4];

    logic signed [DW-1:0]  dy [2];
    logic signed [PYW-1:0] py_next [2];
    logic signed [LW-1:0]  ay_reg [2];
    logic signed [PYW-1:0] py_reg [2];

    logic signed [VW-1:0]  vy_next [2];
    logic signed [VW-1:0]  vy_reg [2];

    logic signed [EW-1:0]  dz;
    logic signed [PZW-1:0] pz_next;
    logic signed [VW-1:0]  az_reg;
    logic signed [PZW-1:0] pz_reg;

    logic signed [PZW:0]     res_sum;
    logic [M_DATA_W-1:0]     res_sat;
    logic [M_DATA_W-1:0]     value_reg;
    logic [M_USER_W-1:0]     status_reg;

    assign en_out = !out_valid_reg || m_tready;
    assign en6 = !v6_reg || en_out;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign in_ready = en3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en3) v3_reg <= in_valid;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en_out) out_valid_reg <= v6_reg;
        end
    end

    // Corner fetch and the x lerp.
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            case (in_vol)
                VOL_ELEV: q_sel[c] = elev_q[{in_corner.sel_y[(c / 2) % 2],
                                             in_corner.sel_x[c % 2]}];
                VOL_PWAVE: q_sel[c] = pw_q[{in_corner.sel_z[c / 4],
                                            in_corner.sel_y[(c / 2) % 2],
                                            in_corner.sel_x[c % 2]}];
                VOL_SWAVE: q_sel[c] = sw_q[{in_corner.sel_z[c / 4],
                                            in_corner.sel_y[(c / 2) % 2],
                                            in_corner.sel_x[c % 2]}];
                default: q_sel[c] = '0;
            endcase
        end
        for (int r = 0; r < 4; r++) begin
            dq[r] = (SAMPLE_W+1)'(q_sel[2*r+1]) - (SAMPLE_W+1)'(q_sel[2*r]);
            xl_next[r] = (LW'(q_sel[2*r]) <<< F) + LW'(LW'(dq[r]) * LW'(in_fx));
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            xl_reg <= xl_next;
            meta3_reg <= in_meta;
            fy3_reg <= in_fy;
            fz3_reg <= in_fz;
        end
    end

    always_comb begin
        for (int z = 0; z < 2; z++) begin
            dy[z] = DW'(xl_reg[2*z+1]) - DW'(xl_reg[2*z]);
            py_next[z] = PYW'(dy[z]) * PYW'(fy3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int z = 0; z < 2; z++) begin
                ay_reg[z] <= xl_reg[2*z];
                py_reg[z] <= py_next[z];
            end
            meta4_reg <= meta3_reg;
            fz4_reg <= fz3_reg;
        end
    end

    always_comb begin
        for (int z = 0; z < 2; z++) begin
            vy_next[z] = VW'(PZW'(ay_reg[z]) + scale_down(PZW'(py_reg[z])));
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            vy_reg <= vy_next;
            meta5_reg <= meta4_reg;
            fz5_reg <= fz4_reg;
        end
    end

    always_comb begin
        dz = EW'(vy_reg[1]) - EW'(vy_reg[0]);
        pz_next = PZW'(dz) * PZW'(fz5_reg);
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            az_reg <= vy_reg[0];
            pz_reg <= pz_next;
            meta6_reg <= meta5_reg;
        end
    end

    always_comb begin
        res_sum = (PZW+1)'(az_reg) + (PZW+1)'(scale_down(pz_reg));
        if (res_sum > VAL_MAX) begin
            res_sat = M_DATA_W'(VAL_MAX);
        end else if (res_sum < VAL_MIN) begin
            res_sat = M_DATA_W'(VAL_MIN);
        end else begin
            res_sat = M_DATA_W'(res_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            if (meta6_reg.store) begin
                value_reg <= '0;
                status_reg <= STATUS_STORED;
            end else if (meta6_reg.outside) begin
                value_reg <= OUTSIDE_VALUE;
                status_reg <= STATUS_OUTSIDE;
            end else begin
                value_reg <= res_sat;
                status_reg <= STATUS_SAMPLED;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = value_reg;
    assign m_tuser = status_reg;

endmodule
`default_nettype wire

>>> hdl/trilinear_grid_sampler_core.sv
`default_nettype none
// Throughput: one item per cycle unless m_tready stalls; each velocity grid has eight
// parity banks and the elevation grid four, so all corners of a query are read together.
// The pipeline stalls stage by stage, so empty stages keep filling while a result waits.
// Reset (aresetn, synchronous, active low) clears the valid bits and sets the size
// registers to 64 cells and 16 layers; the sample memories are not cleared.
module trilinear_grid_sampler_core #(
    parameter int MAX_CELLS_X = 64,
    parameter int MAX_CELLS_Y = 64,
    parameter int MAX_LAYERS = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, sample_value
    input  logic [tgs_pkg::S_DATA_W-1:0]      s_tdata,
    // kind, volume
    input  logic [tgs_pkg::S_USER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // value
    output logic [tgs_pkg::M_DATA_W-1:0]      m_tdata,
    // status
    output logic [tgs_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                              cfg_we,
    input  logic [tgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tgs_pkg::*;

    localparam int XW = $clog2(MAX_CELLS_X);
    localparam int YW = $clog2(MAX_CELLS_Y);
    localparam int ZW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int XBW = (XW > 1) ? XW - 1 : 1;
    localparam int YBW = (YW > 1) ? YW - 1 : 1;
    localparam int ZBW = (ZW > 1) ? ZW - 1 : 1;
    localparam int EAW = YBW + XBW;
    localparam int VAW = ZBW + YBW + XBW;

    logic [6:0] elev_x_reg, elev_y_reg, pwave_x_reg, pwave_y_reg, swave_x_reg, swave_y_reg;
    logic [4:0] layer_reg;

    function automatic logic [XW:0] eff_x(input logic [6:0] r);
        if (r == '0) return (XW+1)'(1);
        else if (32'(r) > MAX_CELLS_X) return (XW+1)'(MAX_CELLS_X);
        else return (XW+1)'(r);
    endfunction

    function automatic logic [YW:0] eff_y(input logic [6:0] r);
        if (r == '0) return (YW+1)'(1);
        else if (32'(r) > MAX_CELLS_Y) return (YW+1)'(MAX_CELLS_Y);
        else return (YW+1)'(r);
    endfunction

    function automatic logic [ZW:0] eff_z(input logic [4:0] r);
        if (r == '0) return (ZW+1)'(1);
        else if (32'(r) > MAX_LAYERS) return (ZW+1)'(MAX_LAYERS);
        else return (ZW+1)'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elev_x_reg <= 7'd64;
            elev_y_reg <= 7'd64;
            pwave_x_reg <= 7'd64;
            pwave_y_reg <= 7'd64;
            swave_x_reg <= 7'd64;
            swave_y_reg <= 7'd64;
            layer_reg <= 5'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ELEV_X: elev_x_reg <= cfg_wdata;
                CFG_ELEV_Y: elev_y_reg <= cfg_wdata;
                CFG_PWAVE_X: pwave_x_reg <= cfg_wdata;
                CFG_PWAVE_Y: pwave_y_reg <= cfg_wdata;
                CFG_SWAVE_X: swave_x_reg <= cfg_wdata;
                CFG_SWAVE_Y: swave_y_reg <= cfg_wdata;
                CFG_LAYERS: layer_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    logic              in_kind;
    logic [1:0]        in_vol;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [5:0]        cell_x, cell_y;
    logic [3:0]        cell_z, cell_z_eff;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [XW:0]       size_x;
    logic [YW:0]       size_y;
    logic [ZW:0]       size_z;
    logic              vol_known;

    assign in_kind = s_tuser[0];
    assign in_vol = s_tuser[2:1];
    assign pos_x = s_tdata[15:0];
    assign pos_y = s_tdata[31:16];
    assign pos_z = s_tdata[47:32];
    assign cell_x = s_tdata[53:48];
    assign cell_y = s_tdata[59:54];
    assign cell_z = s_tdata[63:60];
    assign sample_value = s_tdata[79:64];
    assign cell_z_eff = (in_vol == VOL_ELEV) ? 4'd0 : cell_z;

    always_comb begin
        vol_known = 1'b1;
        case (in_vol)
            VOL_ELEV: begin
                size_x = eff_x(elev_x_reg);
                size_y = eff_y(elev_y_reg);
                size_z = (ZW+1)'(1);
            end
            VOL_PWAVE: begin
                size_x = eff_x(pwave_x_reg);
                size_y = eff_y(pwave_y_reg);
                size_z = eff_z(layer_reg);
            end
            VOL_SWAVE: begin
                size_x = eff_x(swave_x_reg);
                size_y = eff_y(swave_y_reg);
                size_z = eff_z(layer_reg);
            end
            default: begin
                vol_known = 1'b0;
                size_x = (XW+1)'(1);
                size_y = (YW+1)'(1);
                size_z = (ZW+1)'(1);
            end
        endcase
    end

    logic en1, en2, en3;
    logic v1_reg, v2_reg;

    logic                       store1_reg, vol_ok1_reg, wok1_reg;
    logic [1:0]                 vol1_reg, vol2_reg;
    logic [XW-1:0]              wcx_reg;
    logic [YW-1:0]              wcy_reg;
    logic [ZW-1:0]              wcz_reg;
    logic signed [SAMPLE_W-1:0] wval_reg;

    logic [XW-1:0] ix0, ix1;
    logic [YW-1:0] iy0, iy1;
    logic [ZW-1:0] iz0, iz1;
    logic signed [FRAC_BITS:0] fx1, fy1, fz1;
    logic ox1, oy1, oz1;

    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            store1_reg <= (in_kind == KIND_STORE);
            vol1_reg <= in_vol;
            vol_ok1_reg <= vol_known;
            wcx_reg <= XW'(cell_x);
            wcy_reg <= YW'(cell_y);
            wcz_reg <= ZW'(cell_z_eff);
            wval_reg <= sample_value;
            wok1_reg <= (32'(cell_x) < MAX_CELLS_X) && (32'(cell_y) < MAX_CELLS_Y) &&
                        (32'(cell_z_eff) < MAX_LAYERS);
        end
    end

    tgs_coord #(.IW(XW), .FRAC_BITS(FRAC_BITS)) u_coord_x (
        .aclk(aclk), .en(en1), .pos(pos_x), .size(size_x),
        .idx0(ix0), .idx1(ix1), .frac(fx1), .outside(ox1)
    );

    tgs_coord #(.IW(YW), .FRAC_BITS(FRAC_BITS)) u_coord_y (
        .aclk(aclk), .en(en1), .pos(pos_y), .size(size_y),
        .idx0(iy0), .idx1(iy1), .frac(fy1), .outside(oy1)
    );

    tgs_coord #(.IW(ZW), .FRAC_BITS(FRAC_BITS)) u_coord_z (
        .aclk(aclk), .en(en1), .pos(pos_z), .size(size_z),
        .idx0(iz0), .idx1(iz1), .frac(fz1), .outside(oz1)
    );

    // The two corners along an axis differ in parity unless clamped onto one cell,
    // so each parity bank is read at one address.
    logic [XBW-1:0] xh [2];
    logic [YBW-1:0] yh [2];
    logic [ZBW-1:0] zh [2];
    tgs_corner_t    corner1;
    tgs_meta_t      meta1;

    always_comb begin
        xh[0] = XBW'((ix0[0] ? ix1 : ix0) >> 1);
        xh[1] = XBW'((ix0[0] ? ix0 : ix1) >> 1);
        yh[0] = YBW'((iy0[0] ? iy1 : iy0) >> 1);
        yh[1] = YBW'((iy0[0] ? iy0 : iy1) >> 1);
        zh[0] = ZBW'((iz0[0] ? iz1 : iz0) >> 1);
        zh[1] = ZBW'((iz0[0] ? iz0 : iz1) >> 1);
        corner1.sel_x = {ix1[0], ix0[0]};
        corner1.sel_y = {iy1[0], iy0[0]};
        corner1.sel_z = {iz1[0], iz0[0]};
        meta1.store = store1_reg;
        meta1.outside = !vol_ok1_reg || ox1 || oy1 || oz1;
    end

    tgs_meta_t   meta2_reg;
    tgs_corner_t corner2_reg;
    logic signed [FRAC_BITS:0] fx2_reg, fy2_reg, fz2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            meta2_reg <= meta1;
            corner2_reg <= corner1;
            vol2_reg <= vol1_reg;
            fx2_reg <= fx1;
            fy2_reg <= fy1;
            fz2_reg <= fz1;
        end
    end

    logic           wr_go;
    logic [2:0]     wpar;
    logic [XBW-1:0] wxh;
    logic [YBW-1:0] wyh;
    logic [ZBW-1:0] wzh;
    logic [3:0]     elev_we;
    logic [7:0]     pw_we, sw_we;
    logic signed [SAMPLE_W-1:0] elev_q [4];
    logic signed [SAMPLE_W-1:0] pw_q [8];
    logic signed [SAMPLE_W-1:0] sw_q [8];

    assign wr_go = v1_reg && store1_reg && wok1_reg && en2;
    assign wpar = {wcz_reg[0], wcy_reg[0], wcx_reg[0]};
    assign wxh = XBW'(wcx_reg >> 1);
    assign wyh = YBW'(wcy_reg >> 1);
    assign wzh = ZBW'(wcz_reg >> 1);

    for (genvar b = 0; b < 4; b++) begin : g_elev
        assign elev_we[b] = wr_go && (vol1_reg == VOL_ELEV) && (wpar == 3'(b));
        tgs_bank #(.AW(EAW)) u_bank (
            .aclk(aclk), .we(elev_we[b]), .waddr({wyh, wxh}), .wdata(wval_reg),
            .re(en2), .raddr({yh[(b / 2) % 2], xh[b % 2]}), .rdata(elev_q[b])
        );
    end

    for (genvar b = 0; b < 8; b++) begin : g_vel
        assign pw_we[b] = wr_go && (vol1_reg == VOL_PWAVE) && (wpar == 3'(b));
        assign sw_we[b] = wr_go && (vol1_reg == VOL_SWAVE) && (wpar == 3'(b));
        tgs_bank #(.AW(VAW)) u_pw_bank (
            .aclk(aclk), .we(pw_we[b]), .waddr({wzh, wyh, wxh}), .wdata(wval_reg),
            .re(en2), .raddr({zh[b / 4], yh[(b / 2) % 2], xh[b % 2]}), .rdata(pw_q[b])
        );
        tgs_bank #(.AW(VAW)) u_sw_bank (
            .aclk(aclk), .we(sw_we[b]), .waddr({wzh, wyh, wxh}), .wdata(wval_reg),
            .re(en2), .raddr({zh[b / 4], yh[(b / 2) % 2], xh[b % 2]}), .rdata(sw_q[b])
        );
    end

    tgs_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(v2_reg),
        .in_ready(en3),
        .in_meta(meta2_reg),
        .in_vol(vol2_reg),
        .in_corner(corner2_reg),
        .in_fx(fx2_reg),
        .in_fy(fy2_reg),
        .in_fz(fz2_reg),
        .elev_q(elev_q),
        .pw_q(pw_q),
        .sw_q(sw_q),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    a_one_bank_written: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({elev_we, pw_we, sw_we}))
        else $error("more than one sample bank written in a cycle");

    a_store_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && store1_reg && en2) |=> (v2_reg && meta2_reg.store))
        else $error("store item lost between first and second stage");

    a_corner_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !store1_reg && !meta1.outside) |->
        ((XW+1)'(ix1) < eff_x(vol1_reg == VOL_ELEV ? elev_x_reg :
                              vol1_reg == VOL_PWAVE ? pwave_x_reg : swave_x_reg)))
        else $error("clamped x corner beyond grid size");

    a_write_only_on_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (|{elev_we, pw_we, sw_we}) |-> (v1_reg && store1_reg && s_tready == en1))
        else $error("sample bank written without a store item");

endmodule
`default_nettype wire
